// ===== hw/rtl/ifl_pkg.sv =====
package ifl_pkg;

    typedef enum logic [2:0] {
        MODE_STRETCH = 3'd0,
        MODE_CENTER  = 3'd1,
        MODE_FIT     = 3'd2,
        MODE_FILL    = 3'd3,
        MODE_TILE    = 3'd4,
        MODE_CTILE   = 3'd5
    } t_mode;

    // which division the layout needs: none, height from width, width from height
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_A    = 2'd1,
        SEL_B    = 2'd2
    } t_sel;

    typedef struct packed {
        t_mode mode;
        t_sel  sel;
        logic  scal;
        logic  negx;
        logic  negy;
    } t_ctrl;

endpackage

// ===== hw/rtl/ifl_prep.sv =====
module ifl_prep #(
    parameter int DIM_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2:0]              i_func,
    input  logic [DIM_BITS-1:0]     i_sw,
    input  logic [DIM_BITS-1:0]     i_sh,
    input  logic [DIM_BITS-1:0]     i_iw,
    input  logic [DIM_BITS-1:0]     i_ih,
    input  logic                    i_scal,
    output logic                    o_valid,
    output logic [2*DIM_BITS-1:0]   o_num0,
    output logic [DIM_BITS-1:0]     o_den0,
    output logic [2*DIM_BITS-1:0]   o_num1,
    output logic [DIM_BITS-1:0]     o_den1,
    output ifl_pkg::t_ctrl          o_ctrl,
    output logic [DIM_BITS-1:0]     o_sw,
    output logic [DIM_BITS-1:0]     o_sh,
    output logic [DIM_BITS-1:0]     o_iw,
    output logic [DIM_BITS-1:0]     o_ih
);
    import ifl_pkg::*;

    localparam int D = DIM_BITS;
    localparam int N = 2 * DIM_BITS;
    localparam logic [D-1:0] ONE = D'(1);

    // stage 1: clamp, products, half differences
    logic [D-1:0] n_iw, n_ih;
    t_mode        n_mode;
    logic [D:0]   n_dx, n_dy, n_ax, n_ay;

    logic         r1_valid;
    t_mode        r1_mode;
    logic         r1_scal;
    logic [D-1:0] r1_sw, r1_sh, r1_iw, r1_ih;
    logic [N-1:0] r1_pa, r1_pb;
    logic [D-1:0] r1_hx, r1_hy;
    logic         r1_negx, r1_negy;

    always_comb begin
        n_iw = i_scal ? i_sw : i_iw;
        n_ih = i_scal ? i_sh : i_ih;
        if (n_iw == '0) n_iw = ONE;
        if (n_ih == '0) n_ih = ONE;
        case (i_func)
            MODE_CENTER: n_mode = MODE_CENTER;
            MODE_FIT:    n_mode = MODE_FIT;
            MODE_FILL:   n_mode = MODE_FILL;
            MODE_TILE:   n_mode = MODE_TILE;
            MODE_CTILE:  n_mode = MODE_CTILE;
            default:     n_mode = MODE_STRETCH;
        endcase
        n_dx = {1'b0, i_sw} - {1'b0, n_iw};
        n_dy = {1'b0, i_sh} - {1'b0, n_ih};
        n_ax = n_dx[D] ? (~n_dx + 1'b1) : n_dx;
        n_ay = n_dy[D] ? (~n_dy + 1'b1) : n_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= n_mode;
            r1_scal <= i_scal;
            r1_sw   <= i_sw;
            r1_sh   <= i_sh;
            r1_iw   <= n_iw;
            r1_ih   <= n_ih;
            r1_pa   <= {{D{1'b0}}, i_sw} * {{D{1'b0}}, n_ih};
            r1_pb   <= {{D{1'b0}}, i_sh} * {{D{1'b0}}, n_iw};
            // magnitude of the truncated half difference
            r1_hx   <= n_ax[D:1];
            r1_hy   <= n_ay[D:1];
            r1_negx <= n_dx[D];
            r1_negy <= n_dy[D];
        end
    end

    // stage 2: aspect compare and divider operand selection
    t_sel         n_sel;
    logic [N-1:0] n_num0, n_num1;
    logic [D-1:0] n_den0, n_den1;

    logic         r2_valid;
    t_ctrl        r2_ctrl;
    logic [N-1:0] r2_num0, r2_num1;
    logic [D-1:0] r2_den0, r2_den1;
    logic [D-1:0] r2_sw, r2_sh, r2_iw, r2_ih;

    always_comb begin
        n_sel = SEL_NONE;
        case (r1_mode)
            MODE_CENTER: begin
                if ((r1_sw < r1_iw) && (r1_iw > r1_ih)) begin
                    n_sel = SEL_A;
                end else if (r1_sh < r1_ih) begin
                    n_sel = SEL_B;
                end
            end
            MODE_FIT:  n_sel = (r1_pa > r1_pb) ? SEL_B : SEL_A;
            MODE_FILL: n_sel = (r1_pa > r1_pb) ? SEL_A : SEL_B;
            default:   n_sel = SEL_NONE;
        endcase

        n_num0 = '0;
        n_den0 = ONE;
        n_num1 = '0;
        n_den1 = ONE;
        if (r1_mode == MODE_CTILE) begin
            n_num0 = {{D{1'b0}}, r1_hx};
            n_den0 = r1_iw;
            n_num1 = {{D{1'b0}}, r1_hy};
            n_den1 = r1_ih;
        end else begin
            case (n_sel)
                SEL_A: begin
                    n_num0 = r1_pa;
                    n_den0 = r1_iw;
                end
                SEL_B: begin
                    n_num0 = r1_pb;
                    n_den0 = r1_ih;
                end
                default: begin
                    n_num0 = '0;
                    n_den0 = ONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ctrl.mode <= r1_mode;
            r2_ctrl.sel  <= n_sel;
            r2_ctrl.scal <= r1_scal;
            r2_ctrl.negx <= r1_negx;
            r2_ctrl.negy <= r1_negy;
            r2_num0      <= n_num0;
            r2_den0      <= n_den0;
            r2_num1      <= n_num1;
            r2_den1      <= n_den1;
            r2_sw        <= r1_sw;
            r2_sh        <= r1_sh;
            r2_iw        <= r1_iw;
            r2_ih        <= r1_ih;
        end
    end

    assign o_valid = r2_valid;
    assign o_ctrl  = r2_ctrl;
    assign o_num0  = r2_num0;
    assign o_den0  = r2_den0;
    assign o_num1  = r2_num1;
    assign o_den1  = r2_den1;
    assign o_sw    = r2_sw;
    assign o_sh    = r2_sh;
    assign o_iw    = r2_iw;
    assign o_ih    = r2_ih;

endmodule

// ===== hw/rtl/ifl_div.sv =====
module ifl_div #(
    parameter int NUM_BITS  = 28,
    parameter int DEN_BITS  = 14,
    parameter int STEP_BITS = 4,
    parameter int SIDE_BITS = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NUM_BITS-1:0]   i_num0,
    input  logic [DEN_BITS-1:0]   i_den0,
    input  logic [NUM_BITS-1:0]   i_num1,
    input  logic [DEN_BITS-1:0]   i_den1,
    input  logic [SIDE_BITS-1:0]  i_side,
    output logic                  o_valid,
    output logic [NUM_BITS-1:0]   o_quo0,
    output logic [DEN_BITS-1:0]   o_rem0,
    output logic [DEN_BITS-1:0]   o_rem1,
    output logic [SIDE_BITS-1:0]  o_side
);
    import ifl_pkg::*;

    localparam int STAGES = (NUM_BITS + STEP_BITS - 1) / STEP_BITS;

    // restoring division, STEP_BITS quotient bits per stage; quotient shifts
    // into the numerator register as its bits shift out
    function automatic logic [NUM_BITS+DEN_BITS-1:0] f_steps(
        input logic [NUM_BITS-1:0] a,
        input logic [DEN_BITS-1:0] rem,
        input logic [DEN_BITS-1:0] den,
        input int                  base
    );
        logic [NUM_BITS-1:0] x;
        logic [DEN_BITS-1:0] r;
        logic [DEN_BITS:0]   t;
        int                  k;
        x = a;
        r = rem;
        for (k = 0; k < STEP_BITS; k++) begin
            if (base + k < NUM_BITS) begin
                t = {r, x[NUM_BITS-1]};
                x = {x[NUM_BITS-2:0], 1'b0};
                if (t >= {1'b0, den}) begin
                    t    = t - {1'b0, den};
                    x[0] = 1'b1;
                end
                r = t[DEN_BITS-1:0];
            end
        end
        return {x, r};
    endfunction

    logic [NUM_BITS-1:0]  r_a0   [STAGES];
    logic [NUM_BITS-1:0]  r_a1   [STAGES];
    logic [DEN_BITS-1:0]  r_r0   [STAGES];
    logic [DEN_BITS-1:0]  r_r1   [STAGES];
    logic [DEN_BITS-1:0]  r_d0   [STAGES];
    logic [DEN_BITS-1:0]  r_d1   [STAGES];
    logic [SIDE_BITS-1:0] r_side [STAGES];
    logic                 r_v    [STAGES];

    logic [NUM_BITS-1:0]  n_a0   [STAGES];
    logic [NUM_BITS-1:0]  n_a1   [STAGES];
    logic [DEN_BITS-1:0]  n_r0   [STAGES];
    logic [DEN_BITS-1:0]  n_r1   [STAGES];
    logic [DEN_BITS-1:0]  n_d0   [STAGES];
    logic [DEN_BITS-1:0]  n_d1   [STAGES];
    logic [SIDE_BITS-1:0] n_side [STAGES];
    logic                 n_v    [STAGES];

    always_comb begin : c_stages
        logic [NUM_BITS-1:0]  a0, a1;
        logic [DEN_BITS-1:0]  rr0, rr1, d0, d1;
        logic [SIDE_BITS-1:0] sd;
        logic                 v;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                a0  = i_num0;
                a1  = i_num1;
                rr0 = '0;
                rr1 = '0;
                d0  = i_den0;
                d1  = i_den1;
                sd  = i_side;
                v   = i_valid;
            end else begin
                a0  = r_a0[s-1];
                a1  = r_a1[s-1];
                rr0 = r_r0[s-1];
                rr1 = r_r1[s-1];
                d0  = r_d0[s-1];
                d1  = r_d1[s-1];
                sd  = r_side[s-1];
                v   = r_v[s-1];
            end
            {n_a0[s], n_r0[s]} = f_steps(a0, rr0, d0, s * STEP_BITS);
            {n_a1[s], n_r1[s]} = f_steps(a1, rr1, d1, s * STEP_BITS);
            n_d0[s]   = d0;
            n_d1[s]   = d1;
            n_side[s] = sd;
            n_v[s]    = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            for (int s = 0; s < STAGES; s++) r_v[s] <= n_v[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STAGES; s++) begin
                r_a0[s]   <= n_a0[s];
                r_a1[s]   <= n_a1[s];
                r_r0[s]   <= n_r0[s];
                r_r1[s]   <= n_r1[s];
                r_d0[s]   <= n_d0[s];
                r_d1[s]   <= n_d1[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_quo0  = r_a0[STAGES-1];
    assign o_rem0  = r_r0[STAGES-1];
    assign o_rem1  = r_r1[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// ===== hw/rtl/ifl_place.sv =====
module ifl_place #(
    parameter int DIM_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*DIM_BITS-1:0]   i_quo0,
    input  logic [DIM_BITS-1:0]     i_rem0,
    input  logic [DIM_BITS-1:0]     i_rem1,
    input  ifl_pkg::t_ctrl          i_ctrl,
    input  logic [DIM_BITS-1:0]     i_sw,
    input  logic [DIM_BITS-1:0]     i_sh,
    input  logic [DIM_BITS-1:0]     i_iw,
    input  logic [DIM_BITS-1:0]     i_ih,
    output logic                    o_valid,
    output logic [2*DIM_BITS-1:0]   o_w,
    output logic [2*DIM_BITS-1:0]   o_h,
    output logic [2*DIM_BITS-1:0]   o_px,
    output logic [2*DIM_BITS-1:0]   o_py,
    output logic                    o_tiled
);
    import ifl_pkg::*;

    localparam int D = DIM_BITS;
    localparam int N = 2 * DIM_BITS;

    // (a - b) / 2 truncated toward zero, kept to N bits two's complement
    function automatic logic [N-1:0] f_half(input logic [N-1:0] a, input logic [N-1:0] b);
        logic [N:0] d;
        d = {1'b0, a} - {1'b0, b};
        d = d + {{N{1'b0}}, d[N]};
        return d[N:1];
    endfunction

    logic [N-1:0] sw_x, sh_x, iw_x, ih_x, r0_x, r1_x;
    logic [N-1:0] n_w, n_h, n_px, n_py;
    logic         n_tiled;

    logic         r_valid;
    logic [N-1:0] r_w, r_h, r_px, r_py;
    logic         r_tiled;

    always_comb begin
        sw_x    = {{D{1'b0}}, i_sw};
        sh_x    = {{D{1'b0}}, i_sh};
        iw_x    = {{D{1'b0}}, i_iw};
        ih_x    = {{D{1'b0}}, i_ih};
        r0_x    = {{D{1'b0}}, i_rem0};
        r1_x    = {{D{1'b0}}, i_rem1};
        n_w     = sw_x;
        n_h     = sh_x;
        n_px    = '0;
        n_py    = '0;
        n_tiled = 1'b0;
        case (i_ctrl.mode)
            MODE_CENTER, MODE_FIT, MODE_FILL: begin
                case (i_ctrl.sel)
                    SEL_A: begin
                        n_w = sw_x;
                        n_h = i_quo0;
                    end
                    SEL_B: begin
                        n_w = i_quo0;
                        n_h = sh_x;
                    end
                    default: begin
                        n_w = iw_x;
                        n_h = ih_x;
                    end
                endcase
                n_px = f_half(sw_x, n_w);
                n_py = f_half(sh_x, n_h);
            end
            MODE_TILE: begin
                n_w     = iw_x;
                n_h     = ih_x;
                n_tiled = 1'b1;
            end
            MODE_CTILE: begin
                n_w     = iw_x;
                n_h     = ih_x;
                // remainder takes the sign of the half difference
                n_px    = i_ctrl.negx ? ('0 - iw_x - r0_x) : (r0_x - iw_x);
                n_py    = i_ctrl.negy ? ('0 - ih_x - r1_x) : (r1_x - ih_x);
                n_tiled = 1'b1;
            end
            default: begin
                n_w = sw_x;
                n_h = sh_x;
            end
        endcase
        if (i_ctrl.scal) n_tiled = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w     <= n_w;
            r_h     <= n_h;
            r_px    <= n_px;
            r_py    <= n_py;
            r_tiled <= n_tiled;
        end
    end

    assign o_valid = r_valid;
    assign o_w     = r_w;
    assign o_h     = r_h;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_tiled = r_tiled;

endmodule

// ===== hw/rtl/image_fit_layout.sv =====
// Image placement inside a screen area.
// Slave channel: one beat per request. tdata carries screen width, screen
// height, image width and image height (DIM_BITS each, lowest first); tuser
// carries the mode in bits [2:0] and the scalable flag in bit 3.
// Master channel: one beat per request, in request order. tdata carries
// scaled width, scaled height, left edge and top edge (2*DIM_BITS each,
// positions two's complement); tuser is the tiled flag.
// From an accepted beat to its result beat the request passes through two
// stages for clamping, the products and the aspect compare, one stage per
// four quotient bits of the pipelined divider, and the output register.
// Throughput is one request per cycle unless the receiver stalls; every
// stage holds a valid bit. While the receiver stalls a held result, the
// whole pipeline freezes and the slave side drops tready; nothing is lost
// or repeated. Reset clears all valid bits; the block is empty and ready
// afterwards.
module image_fit_layout #(
    parameter int DIM_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // screen_width, screen_height, image_width, image_height, zero padding
    input  logic [((4*DIM_BITS+7)/8)*8-1:0]       i_s_tdata,
    // func [2:0], scalable [3]
    input  logic [3:0]                            i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // scaled_width, scaled_height, pos_x, pos_y
    output logic [8*DIM_BITS-1:0]                 o_m_tdata,
    // tiled
    output logic                                  o_m_tuser
);
    import ifl_pkg::*;

    localparam int D         = DIM_BITS;
    localparam int N         = 2 * DIM_BITS;
    localparam int STEP_BITS = 4;
    localparam int SIDE_BITS = $bits(t_ctrl) + 4 * DIM_BITS;

    logic                 en;

    logic                 p_valid;
    logic [N-1:0]         p_num0, p_num1;
    logic [D-1:0]         p_den0, p_den1;
    t_ctrl                p_ctrl;
    logic [D-1:0]         p_sw, p_sh, p_iw, p_ih;

    logic                 d_valid;
    logic [N-1:0]         d_quo0;
    logic [D-1:0]         d_rem0, d_rem1;
    logic [SIDE_BITS-1:0] d_side;
    t_ctrl                d_ctrl;
    logic [D-1:0]         d_sw, d_sh, d_iw, d_ih;

    logic [N-1:0]         q_w, q_h, q_px, q_py;

    // advance while the output register is free or being taken
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    ifl_prep #(
        .DIM_BITS (DIM_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_func  (i_s_tuser[2:0]),
        .i_sw    (i_s_tdata[D-1:0]),
        .i_sh    (i_s_tdata[2*D-1:D]),
        .i_iw    (i_s_tdata[3*D-1:2*D]),
        .i_ih    (i_s_tdata[4*D-1:3*D]),
        .i_scal  (i_s_tuser[3]),
        .o_valid (p_valid),
        .o_num0  (p_num0),
        .o_den0  (p_den0),
        .o_num1  (p_num1),
        .o_den1  (p_den1),
        .o_ctrl  (p_ctrl),
        .o_sw    (p_sw),
        .o_sh    (p_sh),
        .o_iw    (p_iw),
        .o_ih    (p_ih)
    );

    ifl_div #(
        .NUM_BITS  (N),
        .DEN_BITS  (D),
        .STEP_BITS (STEP_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_num0  (p_num0),
        .i_den0  (p_den0),
        .i_num1  (p_num1),
        .i_den1  (p_den1),
        .i_side  ({p_ctrl, p_sw, p_sh, p_iw, p_ih}),
        .o_valid (d_valid),
        .o_quo0  (d_quo0),
        .o_rem0  (d_rem0),
        .o_rem1  (d_rem1),
        .o_side  (d_side)
    );

    assign {d_ctrl, d_sw, d_sh, d_iw, d_ih} = d_side;

    ifl_place #(
        .DIM_BITS (DIM_BITS)
    ) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_quo0  (d_quo0),
        .i_rem0  (d_rem0),
        .i_rem1  (d_rem1),
        .i_ctrl  (d_ctrl),
        .i_sw    (d_sw),
        .i_sh    (d_sh),
        .i_iw    (d_iw),
        .i_ih    (d_ih),
        .o_valid (o_m_tvalid),
        .o_w     (q_w),
        .o_h     (q_h),
        .o_px    (q_px),
        .o_py    (q_py),
        .o_tiled (o_m_tuser)
    );

    assign o_m_tdata = {q_py, q_px, q_h, q_w};

endmodule
